// ===== design/sdh_pkg.sv =====
// Package of shared types and constants for the SD card SPI-mode host sequencer.
`timescale 1ns / 1ps
`default_nettype none
package sdh_pkg;

  // Bytes in one data block, and the width of a counter that can hold that count.
  localparam int BLOCK_BYTES = 512;
  localparam int BC_W        = $clog2(BLOCK_BYTES + 1);

  // Configuration register indexes and port widths.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_RESP_POLL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUSY_POLL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OPC_RETRY = 2'd2;

  // Opcodes carried by an input beat.
  typedef enum logic [1:0] {
    OP_EXCHANGE = 2'd0,
    OP_INIT     = 2'd1,
    OP_READ     = 2'd2,
    OP_WRITE    = 2'd3
  } opcode_t;

  // Procedure completion status codes.
  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_IDLE_TIMEOUT  = 3'd1;
  localparam logic [2:0] ST_OPC_TIMEOUT   = 3'd2;
  localparam logic [2:0] ST_BLEN_TIMEOUT  = 3'd3;
  localparam logic [2:0] ST_WCMD_TIMEOUT  = 3'd4;
  localparam logic [2:0] ST_WRITE_FAIL    = 3'd5;
  localparam logic [2:0] ST_RCMD_TIMEOUT  = 3'd6;
  localparam logic [2:0] ST_TOKEN_MISSING = 3'd7;

  // One input item.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] block_number;
    logic [7:0]  miso_byte;
    logic [7:0]  write_byte;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] mosi_byte;
    logic       mosi_valid;
    logic       select_asserted;
    logic       write_taken;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;
    logic       done_res;
    logic [2:0] status;
    logic       busy_res;
  } result_t;

  // Configuration register values handed to the sequencer core.
  typedef struct packed {
    logic [15:0] response_poll_limit;
    logic [15:0] busy_poll_limit;
    logic [15:0] op_cond_retry_limit;
  } cfg_t;

endpackage
`default_nettype wire

// ===== design/sdh_in_if.sv =====
// Interface for the input item channel.
`timescale 1ns / 1ps
`default_nettype none
interface sdh_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] block_number;
  logic [7:0]  miso_byte;
  logic [7:0]  write_byte;

  modport source (output valid, output opcode, output block_number,
                  output miso_byte, output write_byte, input ready);
  modport sink   (input valid, input opcode, input block_number,
                  input miso_byte, input write_byte, output ready);
endinterface
`default_nettype wire

// ===== design/sdh_out_if.sv =====
// Interface for the result item channel.
`timescale 1ns / 1ps
`default_nettype none
interface sdh_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] mosi_byte;
  logic       mosi_valid;
  logic       select_asserted;
  logic       write_taken;
  logic [7:0] read_byte;
  logic       read_valid;
  logic       read_last;
  logic       done_res;
  logic [2:0] status;
  logic       busy_res;

  modport source (output valid, output mosi_byte, output mosi_valid,
                  output select_asserted, output write_taken, output read_byte,
                  output read_valid, output read_last, output done_res,
                  output status, output busy_res, input ready);
  modport sink   (input valid, input mosi_byte, input mosi_valid,
                  input select_asserted, input write_taken, input read_byte,
                  input read_valid, input read_last, input done_res,
                  input status, input busy_res, output ready);
endinterface
`default_nettype wire

// ===== design/sdh_cfg_if.sv =====
// Interface for the configuration write channel.
`timescale 1ns / 1ps
`default_nettype none
interface sdh_cfg_if;
  import sdh_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [CFG_DAT_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface
`default_nettype wire

// ===== design/sd_spi_block_host_sequencer.sv =====
// Top level of the SD card SPI-mode host sequencer.
// The block steers an SD/MMC card in SPI mode one byte exchange at a time.
// in_bus carries items: a start opcode (init, read, write) with a block
// number begins a procedure, and each exchange item brings the card's reply
// to the last byte sent plus the next write data byte on offer.
// out_bus returns one result beat for every input beat: the next byte to
// send, chip select, read data with a last flag, done, status and busy.
// cfg_bus writes the three poll and retry limits; it is always ready. The user
// must write it only while no procedure is running; the block does not enforce this.
// An accepted input beat passes through one input register and one result
// register, with the procedure state machine between them. Throughput is one
// item per cycle while out_bus does not stall.
// When out_bus stalls, the pending result holds and the input register takes
// one more beat before in_bus ready drops.
// Reset (rst_n low at a clock edge) empties both registers, returns the
// sequencer to idle with status ok and loads the default limits.
`timescale 1ns / 1ps
`default_nettype none
module sd_spi_block_host_sequencer (
  input  wire logic clk,
  input  wire logic rst_n,
  sdh_in_if.sink    in_bus,
  sdh_out_if.source out_bus,
  sdh_cfg_if.sink   cfg_bus
);
  import sdh_pkg::*;

  logic     in_valid_r;
  in_item_t in_item_r;
  logic     out_valid_r, out_valid_nxt;
  logic     advance;
  cfg_t     cfg;
  result_t  res;

  // An item moves into the result register whenever that register is free or its beat is being taken.
  assign advance      = in_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !in_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      in_valid_r <= in_bus.valid;
    end
    if (in_bus.ready && in_bus.valid) begin
      in_item_r.opcode       <= in_bus.opcode;
      in_item_r.block_number <= in_bus.block_number;
      in_item_r.miso_byte    <= in_bus.miso_byte;
      in_item_r.write_byte   <= in_bus.write_byte;
    end
  end

  // Result beat valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) out_valid_nxt = 1'b1;
    else if (out_bus.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  sdh_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .cfg     (cfg)
  );

  sdh_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Result channel drive.
  assign out_bus.valid           = out_valid_r;
  assign out_bus.mosi_byte       = res.mosi_byte;
  assign out_bus.mosi_valid      = res.mosi_valid;
  assign out_bus.select_asserted = res.select_asserted;
  assign out_bus.write_taken     = res.write_taken;
  assign out_bus.read_byte       = res.read_byte;
  assign out_bus.read_valid      = res.read_valid;
  assign out_bus.read_last       = res.read_last;
  assign out_bus.done_res        = res.done_res;
  assign out_bus.status          = res.status;
  assign out_bus.busy_res        = res.busy_res;

endmodule
`default_nettype wire

// ===== design/sdh_cfg.sv =====
// Configuration registers holding the poll and retry limits.
`timescale 1ns / 1ps
`default_nettype none
module sdh_cfg (
  input  wire logic    clk,
  input  wire logic    rst_n,
  sdh_cfg_if.sink      cfg_bus,
  output sdh_pkg::cfg_t cfg
);
  import sdh_pkg::*;

  cfg_t cfg_r;

  // Writes are always taken.
  assign cfg_bus.ready = 1'b1;
  assign cfg       = cfg_r;

  // Register file with reset values; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.response_poll_limit <= 16'd4095;
      cfg_r.busy_poll_limit     <= 16'd65535;
      cfg_r.op_cond_retry_limit <= 16'd1000;
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.reg_index)
        CFG_RESP_POLL: cfg_r.response_poll_limit <= cfg_bus.wdata;
        CFG_BUSY_POLL: cfg_r.busy_poll_limit     <= cfg_bus.wdata;
        CFG_OPC_RETRY: cfg_r.op_cond_retry_limit <= cfg_bus.wdata;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/sdh_core.sv =====
// Sequencer core: procedure state machine and registered result for each item.
`timescale 1ns / 1ps
`default_nettype none
module sdh_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire sdh_pkg::in_item_t item,
  input  wire sdh_pkg::cfg_t    cfg,
  output sdh_pkg::result_t      res
);
  import sdh_pkg::*;

  typedef enum logic [4:0] {
    P_IDLE, P_WAKE, P_CMD0_TX, P_CMD0_POLL, P_CMD1_TX, P_CMD1_POLL,
    P_CMD16_TX, P_CMD16_POLL, P_RD_TX, P_RD_POLL, P_RD_TOKEN, P_RD_DATA,
    P_RD_CRC, P_WR_TX, P_WR_POLL, P_WR_TOKEN, P_WR_DATA, P_WR_CRC,
    P_WR_RESP, P_WR_BUSY
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [BC_W-1:0]   bc_r, bc_nxt;
  logic [15:0]       poll_r, poll_nxt;
  logic [15:0]       retry_r, retry_nxt;
  logic [31:0]       addr_r, addr_nxt;
  logic [2:0]        last_st_r, last_st_nxt;
  logic [7:0]        pend_r, pend_nxt;
  result_t           res_r, res_nxt;

  logic              em;
  logic [7:0]        em_b;
  logic              fin;
  logic [2:0]        fin_st;
  logic [15:0]       poll_inc;
  logic [15:0]       poll_lim;
  logic              poll_to;
  logic [BC_W-1:0]   bc_inc;

  // Byte i of a command frame: code, four argument bytes, then CRC.
  function automatic logic [7:0] cmd_byte(phase_t tx, logic [2:0] idx,
                                          logic [31:0] addr);
    logic [7:0]  code;
    logic [7:0]  crc;
    logic [31:0] arg;
    code = 8'h58;
    crc  = 8'hFF;
    arg  = addr;
    case (tx)
      P_CMD0_TX:  begin code = 8'h40; arg = 32'd0; crc = 8'h95; end
      P_CMD1_TX:  begin code = 8'h41; arg = 32'd0; end
      P_CMD16_TX: begin code = 8'h50; arg = 32'(BLOCK_BYTES); end
      P_RD_TX:    code = 8'h51;
      default:    code = 8'h58;
    endcase
    case (idx)
      3'd0:    cmd_byte = code;
      3'd1:    cmd_byte = arg[31:24];
      3'd2:    cmd_byte = arg[23:16];
      3'd3:    cmd_byte = arg[15:8];
      3'd4:    cmd_byte = arg[7:0];
      default: cmd_byte = crc;
    endcase
  endfunction

  // Poll miss bookkeeping: the busy wait uses its own limit, a wrap counts as timeout.
  assign poll_inc = poll_r + 16'd1;
  assign poll_lim = (phase_r == P_WR_BUSY) ? cfg.busy_poll_limit : cfg.response_poll_limit;
  assign poll_to  = (poll_inc >= poll_lim) || (poll_inc == 16'd0);
  assign bc_inc   = bc_r + BC_W'(1);

  // Next state and result for the item in hand.
  always_comb begin
    phase_nxt   = phase_r;
    bc_nxt      = bc_r;
    poll_nxt    = poll_r;
    retry_nxt   = retry_r;
    addr_nxt    = addr_r;
    last_st_nxt = last_st_r;
    pend_nxt    = pend_r;
    res_nxt     = '0;
    em          = 1'b0;
    em_b        = 8'hFF;
    fin         = 1'b0;
    fin_st      = ST_OK;

    if (opcode_t'(item.opcode) != OP_EXCHANGE) begin
      if (phase_r != P_IDLE) begin
        // A start while busy offers the pending byte again.
        res_nxt.mosi_byte  = pend_r;
        res_nxt.mosi_valid = 1'b1;
      end else begin
        poll_nxt = 16'd0;
        bc_nxt   = BC_W'(1);
        em       = 1'b1;
        if (opcode_t'(item.opcode) == OP_INIT) begin
          retry_nxt = 16'd0;
          phase_nxt = P_WAKE;
          em_b      = 8'hFF;
        end else begin
          addr_nxt  = 32'(item.block_number) * 32'(BLOCK_BYTES);
          phase_nxt = (opcode_t'(item.opcode) == OP_READ) ? P_RD_TX : P_WR_TX;
          em_b      = cmd_byte(phase_nxt, 3'd0, addr_nxt);
        end
      end
    end else if (phase_r != P_IDLE) begin
      unique case (phase_r)
        P_WAKE: begin
          em = 1'b1;
          if (bc_r < BC_W'(10)) begin
            bc_nxt = bc_inc;
            em_b   = 8'hFF;
          end else begin
            phase_nxt = P_CMD0_TX;
            bc_nxt    = BC_W'(1);
            em_b      = cmd_byte(P_CMD0_TX, 3'd0, addr_r);
          end
        end
        P_CMD0_TX, P_CMD1_TX, P_CMD16_TX, P_RD_TX, P_WR_TX: begin
          em = 1'b1;
          if (bc_r < BC_W'(6)) begin
            em_b   = cmd_byte(phase_r, bc_r[2:0], addr_r);
            bc_nxt = bc_inc;
          end else begin
            // Move on to the response poll of this command.
            poll_nxt = 16'd0;
            em_b     = 8'hFF;
            case (phase_r)
              P_CMD0_TX:  phase_nxt = P_CMD0_POLL;
              P_CMD1_TX:  phase_nxt = P_CMD1_POLL;
              P_CMD16_TX: phase_nxt = P_CMD16_POLL;
              P_RD_TX:    phase_nxt = P_RD_POLL;
              default:    phase_nxt = P_WR_POLL;
            endcase
          end
        end
        P_CMD0_POLL: begin
          if (item.miso_byte == 8'h01) begin
            retry_nxt = 16'd1;
            phase_nxt = P_CMD1_TX;
            bc_nxt    = BC_W'(1);
            em        = 1'b1;
            em_b      = cmd_byte(P_CMD1_TX, 3'd0, addr_r);
          end else begin
            poll_nxt = poll_inc;
            if (poll_to) begin
              fin = 1'b1; fin_st = ST_IDLE_TIMEOUT;
            end else em = 1'b1;
          end
        end
        P_CMD1_POLL: begin
          if (item.miso_byte == 8'h00) begin
            phase_nxt = P_CMD16_TX;
            bc_nxt    = BC_W'(1);
            em        = 1'b1;
            em_b      = cmd_byte(P_CMD16_TX, 3'd0, addr_r);
          end else begin
            poll_nxt = poll_inc;
            if (!poll_to) em = 1'b1;
            else if (retry_r >= cfg.op_cond_retry_limit) begin
              fin = 1'b1; fin_st = ST_OPC_TIMEOUT;
            end else begin
              // Send CMD1 again.
              retry_nxt = retry_r + 16'd1;
              phase_nxt = P_CMD1_TX;
              bc_nxt    = BC_W'(1);
              em        = 1'b1;
              em_b      = cmd_byte(P_CMD1_TX, 3'd0, addr_r);
            end
          end
        end
        P_CMD16_POLL: begin
          if (item.miso_byte == 8'h00) begin
            fin = 1'b1; fin_st = ST_OK;
          end else begin
            poll_nxt = poll_inc;
            if (poll_to) begin
              fin = 1'b1; fin_st = ST_BLEN_TIMEOUT;
            end else em = 1'b1;
          end
        end
        P_RD_POLL: begin
          if (item.miso_byte == 8'h00) begin
            phase_nxt = P_RD_TOKEN;
            poll_nxt  = 16'd0;
            em        = 1'b1;
          end else begin
            poll_nxt = poll_inc;
            if (poll_to) begin
              fin = 1'b1; fin_st = ST_RCMD_TIMEOUT;
            end else em = 1'b1;
          end
        end
        P_RD_TOKEN: begin
          if (item.miso_byte == 8'hFE) begin
            phase_nxt = P_RD_DATA;
            bc_nxt    = '0;
            em        = 1'b1;
          end else begin
            poll_nxt = poll_inc;
            if (poll_to) begin
              fin = 1'b1; fin_st = ST_TOKEN_MISSING;
            end else em = 1'b1;
          end
        end
        P_RD_DATA: begin
          res_nxt.read_byte  = item.miso_byte;
          res_nxt.read_valid = 1'b1;
          em     = 1'b1;
          bc_nxt = bc_inc;
          if (bc_inc >= BC_W'(BLOCK_BYTES)) begin
            res_nxt.read_last = 1'b1;
            phase_nxt         = P_RD_CRC;
            bc_nxt            = '0;
          end
        end
        P_RD_CRC: begin
          bc_nxt = bc_inc;
          if (bc_inc >= BC_W'(2)) begin
            fin = 1'b1; fin_st = ST_OK;
          end else em = 1'b1;
        end
        P_WR_POLL: begin
          if (item.miso_byte == 8'h00) begin
            phase_nxt = P_WR_TOKEN;
            em        = 1'b1;
            em_b      = 8'hFE;
          end else begin
            poll_nxt = poll_inc;
            if (poll_to) begin
              fin = 1'b1; fin_st = ST_WCMD_TIMEOUT;
            end else em = 1'b1;
          end
        end
        P_WR_TOKEN: begin
          phase_nxt           = P_WR_DATA;
          bc_nxt              = BC_W'(1);
          res_nxt.write_taken = 1'b1;
          em                  = 1'b1;
          em_b                = item.write_byte;
        end
        P_WR_DATA: begin
          em = 1'b1;
          if (bc_r < BC_W'(BLOCK_BYTES)) begin
            bc_nxt              = bc_inc;
            res_nxt.write_taken = 1'b1;
            em_b                = item.write_byte;
          end else begin
            phase_nxt = P_WR_CRC;
            bc_nxt    = BC_W'(1);
          end
        end
        P_WR_CRC: begin
          em = 1'b1;
          if (bc_r < BC_W'(2)) bc_nxt = bc_inc;
          else phase_nxt = P_WR_RESP;
        end
        P_WR_RESP: begin
          // Data response token: low nibble 0101 means accepted.
          if (item.miso_byte[3:0] == 4'h5) begin
            phase_nxt = P_WR_BUSY;
            poll_nxt  = 16'd0;
            em        = 1'b1;
          end else begin
            fin = 1'b1; fin_st = ST_WRITE_FAIL;
          end
        end
        P_WR_BUSY: begin
          if (item.miso_byte != 8'h00) begin
            fin = 1'b1; fin_st = ST_OK;
          end else begin
            poll_nxt = poll_inc;
            if (poll_to) begin
              fin = 1'b1; fin_st = ST_WRITE_FAIL;
            end else em = 1'b1;
          end
        end
        default: phase_nxt = P_IDLE;
      endcase
    end

    // Byte offered for the next exchange.
    if (em) begin
      pend_nxt           = em_b;
      res_nxt.mosi_byte  = em_b;
      res_nxt.mosi_valid = 1'b1;
    end

    // End of procedure.
    if (fin) begin
      phase_nxt        = P_IDLE;
      last_st_nxt      = fin_st;
      res_nxt.done_res = 1'b1;
    end

    // Nothing to send once idle; select stays released while waking the card.
    if (phase_nxt == P_IDLE) begin
      res_nxt.mosi_byte  = 8'h00;
      res_nxt.mosi_valid = 1'b0;
    end
    res_nxt.select_asserted = (phase_nxt != P_IDLE) && (phase_nxt != P_WAKE);
    res_nxt.status          = last_st_nxt;
    res_nxt.busy_res        = (phase_nxt != P_IDLE);
  end

  // State and result registers, updated once for each item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= P_IDLE;
      bc_r      <= '0;
      poll_r    <= '0;
      retry_r   <= '0;
      addr_r    <= '0;
      last_st_r <= ST_OK;
      pend_r    <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      bc_r      <= bc_nxt;
      poll_r    <= poll_nxt;
      retry_r   <= retry_nxt;
      addr_r    <= addr_nxt;
      last_st_r <= last_st_nxt;
      pend_r    <= pend_nxt;
    end
    if (step) res_r <= res_nxt;
  end

  assign res = res_r;

endmodule
`default_nettype wire

// ===== verif/sd_spi_block_host_sequencer_tb.sv =====
// Self-checking testbench for the SD card SPI-mode host sequencer, with its own card responder.
`timescale 1ns / 1ps
module sd_spi_block_host_sequencer_tb;
  import sdh_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_PRINTED = 50;

  // Sequencer phases as this bench tracks them.
  typedef enum logic [4:0] {
    PH_IDLE, PH_WAKE, PH_CMD0_TX, PH_CMD0_POLL, PH_CMD1_TX, PH_CMD1_POLL,
    PH_CMD16_TX, PH_CMD16_POLL, PH_RD_TX, PH_RD_POLL, PH_RD_TOKEN, PH_RD_DATA,
    PH_RD_CRC, PH_WR_TX, PH_WR_POLL, PH_WR_TOKEN, PH_WR_DATA, PH_WR_CRC,
    PH_WR_RESP, PH_WR_BUSY
  } seq_phase_t;

  logic clk;
  logic rst_n;

  sdh_in_if  in_bus ();
  sdh_out_if out_bus ();
  sdh_cfg_if cfg_bus ();

  sd_spi_block_host_sequencer dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  // Limits as the block should hold them.
  logic [15:0] lim_resp_poll = 16'd4095;
  logic [15:0] lim_busy_poll = 16'd65535;
  logic [15:0] lim_opc_retry = 16'd1000;

  // Mirror of the sequencer state.
  seq_phase_t  seq_phase       = PH_IDLE;
  logic [9:0]  seq_byte_count  = '0;
  logic [15:0] seq_poll_count  = '0;
  logic [15:0] seq_retry_count = '0;
  logic [31:0] seq_address     = '0;
  logic [1:0]  seq_kind        = '0;
  logic [2:0]  seq_status      = ST_OK;
  logic [7:0]  seq_pending     = '0;
  result_t     next_result;

  result_t expected_results[$];

  // Bookkeeping.
  int unsigned cycle_count   = 0;
  int unsigned items_sent    = 0;
  int unsigned ignored_items = 0;
  int unsigned procedures    = 0;
  int unsigned beats_checked = 0;
  int unsigned mismatches    = 0;
  int unsigned status_seen[8];

  // Stimulus knobs: card miss rates in percent, stray starts, and no-idle stretches.
  int unsigned miss_pct       = 0;
  int unsigned cmd0_miss_pct  = 0;
  int unsigned stray_pct      = 0;
  bit          steady         = 1'b0;
  bit          in_held        = 1'b0;

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // One byte of a command frame: code, four argument bytes, then CRC.
  function automatic logic [7:0] frame_byte(seq_phase_t tx, int unsigned idx);
    logic [7:0]  code;
    logic [31:0] arg;
    logic [7:0]  crc;
    code = 8'h40;
    arg  = '0;
    crc  = 8'hFF;
    case (tx)
      PH_CMD0_TX:  crc = 8'h95;
      PH_CMD1_TX:  code = 8'h41;
      PH_CMD16_TX: begin
        code = 8'h50;
        arg  = BLOCK_BYTES;
      end
      PH_RD_TX: begin
        code = 8'h51;
        arg  = seq_address;
      end
      default: begin
        code = 8'h58;
        arg  = seq_address;
      end
    endcase
    if (idx == 0) return code;
    if (idx >= 5) return crc;
    return arg[8*(4-idx) +: 8];
  endfunction

  function automatic void offer_byte(logic [7:0] b);
    seq_pending            = b;
    next_result.mosi_byte  = b;
    next_result.mosi_valid = 1'b1;
  endfunction

  function automatic void close_procedure(logic [2:0] st);
    seq_phase            = PH_IDLE;
    seq_status           = st;
    next_result.done_res = 1'b1;
    status_seen[st]++;
  endfunction

  function automatic void open_frame(seq_phase_t tx);
    seq_phase      = tx;
    seq_byte_count = 10'd1;
    offer_byte(frame_byte(tx, 0));
  endfunction

  function automatic void open_poll(seq_phase_t p);
    seq_phase      = p;
    seq_poll_count = '0;
    offer_byte(8'hFF);
  endfunction

  // A reply that missed: returns one when the poll budget is spent, else polls again.
  function automatic bit poll_exhausted(logic [15:0] limit);
    seq_poll_count = seq_poll_count + 16'd1;
    if (seq_poll_count >= limit || seq_poll_count == 16'd0) return 1'b1;
    offer_byte(8'hFF);
    return 1'b0;
  endfunction

  // Works out the result beat for one accepted item and advances the mirror state.
  function automatic result_t predict_card_result(in_item_t it);
    logic [7:0] miso;
    logic [7:0] wb;
    miso        = it.miso_byte;
    wb          = it.write_byte;
    next_result = '0;
    if (it.opcode != OP_EXCHANGE) begin
      if (seq_phase != PH_IDLE) begin
        // A start while busy only repeats the pending byte.
        next_result.mosi_byte  = seq_pending;
        next_result.mosi_valid = 1'b1;
      end else begin
        procedures++;
        seq_kind       = it.opcode;
        seq_poll_count = '0;
        if (it.opcode == OP_INIT) begin
          seq_retry_count = '0;
          seq_phase       = PH_WAKE;
          seq_byte_count  = 10'd1;
          offer_byte(8'hFF);
        end else begin
          seq_address = 32'(it.block_number) * BLOCK_BYTES;
          open_frame(it.opcode == OP_READ ? PH_RD_TX : PH_WR_TX);
        end
      end
    end else begin
      case (seq_phase)
        PH_WAKE: begin
          if (seq_byte_count < 10) begin
            seq_byte_count++;
            offer_byte(8'hFF);
          end else begin
            open_frame(PH_CMD0_TX);
          end
        end
        PH_CMD0_TX, PH_CMD1_TX, PH_CMD16_TX, PH_RD_TX, PH_WR_TX: begin
          if (seq_byte_count < 6) begin
            offer_byte(frame_byte(seq_phase, seq_byte_count));
            seq_byte_count++;
          end else begin
            open_poll(seq_phase_t'(seq_phase + 5'd1));
          end
        end
        PH_CMD0_POLL: begin
          if (miso == 8'h01) begin
            seq_retry_count = 16'd1;
            open_frame(PH_CMD1_TX);
          end else if (poll_exhausted(lim_resp_poll)) begin
            close_procedure(ST_IDLE_TIMEOUT);
          end
        end
        PH_CMD1_POLL: begin
          if (miso == 8'h00) begin
            open_frame(PH_CMD16_TX);
          end else if (poll_exhausted(lim_resp_poll)) begin
            if (seq_retry_count >= lim_opc_retry) begin
              close_procedure(ST_OPC_TIMEOUT);
            end else begin
              seq_retry_count = seq_retry_count + 16'd1;
              open_frame(PH_CMD1_TX);
            end
          end
        end
        PH_CMD16_POLL: begin
          if (miso == 8'h00) close_procedure(ST_OK);
          else if (poll_exhausted(lim_resp_poll)) close_procedure(ST_BLEN_TIMEOUT);
        end
        PH_RD_POLL: begin
          if (miso == 8'h00) open_poll(PH_RD_TOKEN);
          else if (poll_exhausted(lim_resp_poll)) close_procedure(ST_RCMD_TIMEOUT);
        end
        PH_RD_TOKEN: begin
          if (miso == 8'hFE) begin
            seq_phase      = PH_RD_DATA;
            seq_byte_count = '0;
            offer_byte(8'hFF);
          end else if (poll_exhausted(lim_resp_poll)) begin
            close_procedure(ST_TOKEN_MISSING);
          end
        end
        PH_RD_DATA: begin
          next_result.read_byte  = miso;
          next_result.read_valid = 1'b1;
          seq_byte_count++;
          if (seq_byte_count >= BLOCK_BYTES) begin
            next_result.read_last = 1'b1;
            seq_phase             = PH_RD_CRC;
            seq_byte_count        = '0;
          end
          offer_byte(8'hFF);
        end
        PH_RD_CRC: begin
          seq_byte_count++;
          if (seq_byte_count >= 2) close_procedure(ST_OK);
          else offer_byte(8'hFF);
        end
        PH_WR_POLL: begin
          if (miso == 8'h00) begin
            seq_phase = PH_WR_TOKEN;
            offer_byte(8'hFE);
          end else if (poll_exhausted(lim_resp_poll)) begin
            close_procedure(ST_WCMD_TIMEOUT);
          end
        end
        PH_WR_TOKEN: begin
          seq_phase               = PH_WR_DATA;
          seq_byte_count          = 10'd1;
          next_result.write_taken = 1'b1;
          offer_byte(wb);
        end
        PH_WR_DATA: begin
          if (seq_byte_count < BLOCK_BYTES) begin
            seq_byte_count++;
            next_result.write_taken = 1'b1;
            offer_byte(wb);
          end else begin
            seq_phase      = PH_WR_CRC;
            seq_byte_count = 10'd1;
            offer_byte(8'hFF);
          end
        end
        PH_WR_CRC: begin
          if (seq_byte_count < 2) begin
            seq_byte_count++;
          end else begin
            seq_phase = PH_WR_RESP;
          end
          offer_byte(8'hFF);
        end
        PH_WR_RESP: begin
          if (miso[3:0] == 4'h5) open_poll(PH_WR_BUSY);
          else close_procedure(ST_WRITE_FAIL);
        end
        PH_WR_BUSY: begin
          if (miso != 8'h00) close_procedure(ST_OK);
          else if (poll_exhausted(lim_busy_poll)) close_procedure(ST_WRITE_FAIL);
        end
        default: seq_phase = PH_IDLE;
      endcase
    end
    if (seq_phase == PH_IDLE) begin
      next_result.mosi_byte  = '0;
      next_result.mosi_valid = 1'b0;
    end
    next_result.select_asserted = (seq_phase != PH_IDLE) && (seq_phase != PH_WAKE);
    next_result.status          = seq_status;
    next_result.busy_res        = (seq_phase != PH_IDLE);
    return next_result;
  endfunction

  // Idle cycles before the next beat on either side.
  function automatic int unsigned pause_cycles();
    if (steady) return 0;
    if ($urandom_range(0, 4) < 2) return 0;
    return $urandom_range(1, 18);
  endfunction

  // A byte that is not the one the sequencer is waiting for.
  function automatic logic [7:0] other_than(logic [7:0] good);
    logic [7:0] r;
    r = $urandom_range(0, 1) ? 8'hFF : 8'($urandom);
    if (r == good) r = ~good;
    return r;
  endfunction

  // The card's reply to the byte last sent, good or missed as the knobs say.
  function automatic logic [7:0] card_reply();
    bit miss;
    miss = ($urandom_range(0, 99) < miss_pct);
    case (seq_phase)
      PH_CMD0_POLL:
        return ($urandom_range(0, 99) < cmd0_miss_pct) ? other_than(8'h01) : 8'h01;
      PH_CMD1_POLL, PH_CMD16_POLL, PH_RD_POLL, PH_WR_POLL:
        return miss ? other_than(8'h00) : 8'h00;
      PH_RD_TOKEN:
        return miss ? other_than(8'hFE) : 8'hFE;
      PH_WR_RESP:
        return {4'($urandom), miss ? (4'($urandom_range(0, 15)) ^ 4'h0) | 4'h8 : 4'h5};
      PH_WR_BUSY:
        return miss ? 8'h00 : other_than(8'h00);
      default:
        return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_block();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_miss(int unsigned top);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return top / 10;
      2:       return top / 3;
      default: return top;
    endcase
  endfunction

  // Reports one mismatch on a single line and counts it.
  task automatic report_mismatch(string field, logic [7:0] got, logic [7:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("ERROR at %0t, beat %0d: %s is 0x%0h, predicted 0x%0h",
               $realtime, beats_checked, field, got, want);
  endtask

  task automatic compare_beat(result_t got, result_t want);
    if (got.mosi_byte !== want.mosi_byte)
      report_mismatch("mosi_byte", got.mosi_byte, want.mosi_byte);
    if (got.mosi_valid !== want.mosi_valid)
      report_mismatch("mosi_valid", got.mosi_valid, want.mosi_valid);
    if (got.select_asserted !== want.select_asserted)
      report_mismatch("select_asserted", got.select_asserted, want.select_asserted);
    if (got.write_taken !== want.write_taken)
      report_mismatch("write_taken", got.write_taken, want.write_taken);
    if (got.read_byte !== want.read_byte)
      report_mismatch("read_byte", got.read_byte, want.read_byte);
    if (got.read_valid !== want.read_valid)
      report_mismatch("read_valid", got.read_valid, want.read_valid);
    if (got.read_last !== want.read_last)
      report_mismatch("read_last", got.read_last, want.read_last);
    if (got.done_res !== want.done_res)
      report_mismatch("done_res", got.done_res, want.done_res);
    if (got.status !== want.status)
      report_mismatch("status", got.status, want.status);
    if (got.busy_res !== want.busy_res)
      report_mismatch("busy_res", got.busy_res, want.busy_res);
  endtask

  // Result checker: every accepted result beat is matched against the oldest prediction.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got = {out_bus.mosi_byte, out_bus.mosi_valid, out_bus.select_asserted,
             out_bus.write_taken, out_bus.read_byte, out_bus.read_valid,
             out_bus.read_last, out_bus.done_res, out_bus.status, out_bus.busy_res};
      if (expected_results.size() == 0) begin
        report_mismatch("beat with nothing predicted, mosi_byte", got.mosi_byte, 8'h00);
      end else begin
        want = expected_results.pop_front();
        compare_beat(got, want);
      end
      beats_checked++;
    end
  end

  // Result side: random stalls between beats.
  initial begin
    int unsigned stall;
    out_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = pause_cycles();
      if (stall > 0) begin
        if (out_bus.ready) out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding.",
             cycle_count, expected_results.size());
    $display("== FAIL ==");
    $finish;
  end

  // Sends one item after a random gap and records its predicted result.
  task automatic send_item(opcode_t op, logic [15:0] blk, logic [7:0] miso,
                           logic [7:0] wb);
    int unsigned gap;
    in_item_t    it;
    gap = pause_cycles();
    if (gap > 0) begin
      if (in_held) begin
        in_bus.valid <= 1'b0;
        in_held = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.opcode       <= op;
    in_bus.block_number <= blk;
    in_bus.miso_byte    <= miso;
    in_bus.write_byte   <= wb;
    in_held = 1'b1;
    do @(posedge clk); while (!in_bus.ready);
    it = {op, blk, miso, wb};
    items_sent++;
    if ((op != OP_EXCHANGE) == (seq_phase != PH_IDLE)) ignored_items++;
    expected_results.push_back(predict_card_result(it));
  endtask

  // Stops input and waits for every predicted result to come back.
  task automatic wait_quiet();
    if (in_held) begin
      in_bus.valid <= 1'b0;
      in_held = 1'b0;
    end
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Writes all three limit registers back to back while the block is idle.
  task automatic set_limits(logic [15:0] resp, logic [15:0] busy, logic [15:0] retry);
    wait_quiet();
    for (int i = 0; i < 3; i++) begin
      case (i)
        0: begin
          cfg_bus.reg_index <= CFG_RESP_POLL;
          cfg_bus.wdata     <= resp;
        end
        1: begin
          cfg_bus.reg_index <= CFG_BUSY_POLL;
          cfg_bus.wdata     <= busy;
        end
        default: begin
          cfg_bus.reg_index <= CFG_OPC_RETRY;
          cfg_bus.wdata     <= retry;
        end
      endcase
      cfg_bus.valid <= 1'b1;
      do @(posedge clk); while (!cfg_bus.ready);
      case (cfg_bus.reg_index)
        CFG_RESP_POLL: lim_resp_poll = cfg_bus.wdata;
        CFG_BUSY_POLL: lim_busy_poll = cfg_bus.wdata;
        default:       lim_opc_retry = cfg_bus.wdata;
      endcase
    end
    cfg_bus.valid <= 1'b0;
  endtask

  // One procedure from start item to completion, the card answering as the knobs say.
  task automatic run_procedure(opcode_t op, logic [15:0] blk);
    send_item(op, blk, 8'($urandom), 8'($urandom));
    while (seq_phase != PH_IDLE) begin
      if ($urandom_range(0, 99) < stray_pct)
        send_item(opcode_t'($urandom_range(1, 3)), pick_block(), 8'($urandom),
                  8'($urandom));
      else
        send_item(OP_EXCHANGE, pick_block(), card_reply(), 8'($urandom));
    end
  endtask

  // Random procedures until the given number of effective items has gone in.
  task automatic run_mixed_traffic(int unsigned budget, int unsigned top_miss);
    int unsigned first;
    first = items_sent - ignored_items;
    while (items_sent - ignored_items - first < budget) begin
      if ($urandom_range(0, 19) == 0)
        send_item(OP_EXCHANGE, pick_block(), 8'($urandom), 8'($urandom));
      miss_pct      = pick_miss(top_miss);
      cmd0_miss_pct = pick_miss(top_miss);
      run_procedure(opcode_t'($urandom_range(1, 3)), pick_block());
    end
  endtask

  // Exchanges while idle give an all-zero result apart from status.
  task automatic test_idle_exchange();
    send_item(OP_EXCHANGE, 16'hFFFF, 8'hFF, 8'hFF);
    send_item(OP_EXCHANGE, 16'h0000, 8'h00, 8'h00);
  endtask

  // Zero limits behave as one: the first miss ends each procedure.
  task automatic test_zero_limits();
    set_limits(16'd0, 16'd0, 16'd0);
    miss_pct      = 100;
    cmd0_miss_pct = 100;
    // Read before any init, with starts thrown in while busy.
    stray_pct = 50;
    run_procedure(OP_READ, 16'hFFFF);
    stray_pct = 0;
    run_procedure(OP_WRITE, 16'h0000);
    // Card leaves idle but CMD1 gets a single attempt only.
    cmd0_miss_pct = 0;
    run_procedure(OP_INIT, 16'hA5A5);
  endtask

  // Full block write and read, the read with no idling on either side, then an init.
  task automatic test_block_transfer();
    set_limits(16'd16, 16'd16, 16'd8);
    miss_pct      = 10;
    cmd0_miss_pct = 10;
    stray_pct     = 5;
    run_procedure(OP_WRITE, pick_block());
    steady = 1'b1;
    run_procedure(OP_READ, pick_block());
    steady = 1'b0;
    run_procedure(OP_INIT, pick_block());
  endtask

  // Mixed traffic under small, frequently changed limits.
  task automatic test_random_small_limits();
    int unsigned first;
    first     = items_sent - ignored_items;
    stray_pct = 4;
    while (items_sent - ignored_items - first < 500) begin
      set_limits(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                 16'($urandom_range(1, 4)));
      run_mixed_traffic(120, 100);
    end
  endtask

  // Mixed traffic at the largest limits, with a cooperative card.
  task automatic test_random_max_limits();
    set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF);
    stray_pct = 3;
    steady    = 1'b1;
    run_mixed_traffic(150, 30);
    steady = 1'b0;
    run_mixed_traffic(200, 30);
  endtask

  // Mixed traffic at the smallest limits, where any miss ends the procedure.
  task automatic test_random_min_limits();
    set_limits(16'd1, 16'd1, 16'd1);
    stray_pct = 4;
    run_mixed_traffic(200, 100);
  endtask

  initial begin
    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.opcode       = OP_EXCHANGE;
    in_bus.block_number = '0;
    in_bus.miso_byte    = '0;
    in_bus.write_byte   = '0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.reg_index   = CFG_RESP_POLL;
    cfg_bus.wdata       = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_exchange();
    test_zero_limits();
    test_block_transfer();
    test_random_small_limits();
    test_random_max_limits();
    test_random_min_limits();

    // Let the last results arrive, then allow for the pipeline to settle.
    wait_quiet();
    repeat (8) @(posedge clk);

    $display("Sent %0d items (%0d ignored) over %0d procedures; checked %0d result beats.",
             items_sent, ignored_items, procedures, beats_checked);
    $display("Completions by status 0..7: %0d %0d %0d %0d %0d %0d %0d %0d; mismatches %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5], status_seen[6], status_seen[7], mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
